// ===== design/tun_pkg.sv =====
// shared types and constants for the triangle unit normal block
package tun_pkg;

  localparam int unsigned VertexDepth = 4096;
  localparam int unsigned SlotW       = 12;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned EdgeW       = 33;
  localparam int unsigned ProdW       = 66;
  localparam int unsigned CrossW      = 67;
  localparam int unsigned MagW        = 31;
  localparam int unsigned L2W         = 64;
  localparam int unsigned NormW       = 16;
  localparam int unsigned KW          = 16;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeTri   = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [SlotW-1:0]         slot;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [SlotW-1:0]         corner_a;
    logic [SlotW-1:0]         corner_b;
    logic [SlotW-1:0]         corner_c;
  } in_item_t;

  typedef struct packed {
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic                    degenerate;
  } out_item_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpWrite,
    OpReadA,
    OpReadB,
    OpReadC,
    OpEdges,
    OpProd,
    OpCross,
    OpShift,
    OpSquare,
    OpSum,
    OpSearchInit,
    OpSearchMul,
    OpSearchPart,
    OpSearchCmp,
    OpFinish
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] comp;
    logic [1:0] sub;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;
    logic fits;
    logic search_done;
  } dp_status_t;

endpackage

// ===== design/tun_ctrl.sv =====
// controller sequencing vertex writes, corner reads and normalisation
module tun_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_mode_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tun_pkg::dp_cmd_t    cmd_o,
  input  tun_pkg::dp_status_t status_i,
  output logic                load_o
);

  typedef enum logic [3:0] {
    StIdle, StRdB, StRdC, StEdge, StProd, StCross, StShift, StSquare, StSum,
    StInit, StMul, StPart, StCmp, StDone
  } state_e;

  state_e     state_q;
  logic [1:0] comp_q, sub_q;
  logic       out_valid_q;
  logic       busy;

  assign busy        = (state_q != StIdle);
  assign in_ready_o  = !busy && !(out_valid_q && !out_ready_i);
  assign load_o      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.comp = comp_q;
    cmd_o.sub  = sub_q;
    case (state_q)
      StIdle: begin
        if (load_o) cmd_o.op = (in_mode_i == tun_pkg::ModeWrite) ? tun_pkg::OpWrite
                                                                  : tun_pkg::OpReadA;
        else cmd_o.op = tun_pkg::OpNone;
      end
      StRdB:    cmd_o.op = tun_pkg::OpReadB;
      StRdC:    cmd_o.op = tun_pkg::OpReadC;
      StEdge:   cmd_o.op = tun_pkg::OpEdges;
      StProd:   cmd_o.op = tun_pkg::OpProd;
      StCross:  cmd_o.op = tun_pkg::OpCross;
      StShift:  cmd_o.op = tun_pkg::OpShift;
      StSquare: cmd_o.op = tun_pkg::OpSquare;
      StSum:    cmd_o.op = tun_pkg::OpSum;
      StInit:   cmd_o.op = tun_pkg::OpSearchInit;
      StMul:    cmd_o.op = tun_pkg::OpSearchMul;
      StPart:   cmd_o.op = tun_pkg::OpSearchPart;
      StCmp:    cmd_o.op = tun_pkg::OpSearchCmp;
      StDone:   cmd_o.op = tun_pkg::OpFinish;
      default:  cmd_o.op = tun_pkg::OpNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      comp_q      <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (load_o && in_mode_i == tun_pkg::ModeTri) state_q <= StRdB;
        end
        StRdB:  state_q <= StRdC;
        StRdC:  state_q <= StEdge;
        StEdge: begin
          state_q <= StProd;
          sub_q   <= '0;
          comp_q  <= '0;
        end
        // the edge products, one at a time on one multiplier
        StProd: begin
          if (sub_q == 2'd2 && comp_q == 2'd1) begin
            state_q <= StCross;
            sub_q   <= '0;
            comp_q  <= '0;
          end else if (comp_q == 2'd1) begin
            comp_q <= '0;
            sub_q  <= sub_q + 2'd1;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        StCross: state_q <= StShift;
        StShift: begin
          if (status_i.zero) state_q <= StDone;
          else if (status_i.fits) begin
            state_q <= StSquare;
            comp_q  <= '0;
          end
        end
        StSquare: begin
          if (comp_q == 2'd2) state_q <= StSum;
          else comp_q <= comp_q + 2'd1;
        end
        StSum: begin
          state_q <= StInit;
          comp_q  <= '0;
        end
        StInit: state_q <= StMul;
        StMul:  state_q <= StPart;
        StPart: state_q <= StCmp;
        StCmp: begin
          if (status_i.search_done) begin
            if (comp_q == 2'd2) state_q <= StDone;
            else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= StInit;
            end
          end else state_q <= StMul;
        end
        StDone: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o) else $error("input taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRdB) |-> $past(state_q) == StIdle) else $error("read order broken");

endmodule

// ===== design/tun_dp.sv =====
// datapath: vertex memory, cross product, scaling and rounding search
module tun_dp (
  input  logic                clk_i,
  input  tun_pkg::in_item_t   item_i,
  input  logic                load_i,
  input  tun_pkg::dp_cmd_t    cmd_i,
  output tun_pkg::dp_status_t status_o,
  output tun_pkg::out_item_t  result_o
);

  localparam int unsigned AW = (tun_pkg::VertexDepth > 1) ? $clog2(tun_pkg::VertexDepth) : 1;
  localparam int unsigned VW = 3 * tun_pkg::CoordW;

  logic [VW-1:0] mem [tun_pkg::VertexDepth];
  logic [VW-1:0] rdata_q;
  logic [AW-1:0] addr;
  logic [tun_pkg::SlotW-1:0] cb_q, cc_q, ca;

  logic signed [tun_pkg::CoordW-1:0] va_q [3];
  logic signed [tun_pkg::CoordW-1:0] vb_q [3];
  logic signed [tun_pkg::EdgeW-1:0]  e0_q [3], e1_q [3];
  logic signed [tun_pkg::ProdW-1:0]  prod_q [6];
  logic signed [tun_pkg::CrossW-1:0] cross_val [3];
  logic [tun_pkg::CrossW-1:0]        mag_q [3];
  logic [2:0]                        neg_q;
  logic [tun_pkg::L2W-1:0]           sq_q [3];
  logic [tun_pkg::L2W-1:0]           l2_q;
  logic [tun_pkg::KW-1:0]            lo_q, hi_q, mid_q;
  logic [tun_pkg::L2W-1:0]           rhs_q;
  logic [31:0]                       t2_q;
  logic [tun_pkg::L2W-1:0]           plo_q, phi_q;
  logic [tun_pkg::L2W+31:0]          lhs_sum;
  logic [tun_pkg::NormW-1:0]         res_q [3];
  logic                              degen_q;
  logic [tun_pkg::KW:0]              mid_c, t_c;

  // corner a is read first, then b and c; read data is registered and lands in the following cycle
  always_comb begin
    ca = item_i.corner_a;
    case (cmd_i.op)
      tun_pkg::OpWrite: addr = item_i.slot[AW-1:0];
      tun_pkg::OpReadB: addr = cb_q[AW-1:0];
      tun_pkg::OpReadC: addr = cc_q[AW-1:0];
      default:          addr = ca[AW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tun_pkg::OpWrite)
      mem[addr] <= {item_i.coord_x, item_i.coord_y, item_i.coord_z};
    else
      rdata_q <= mem[addr];
  end

  logic signed [tun_pkg::EdgeW-1:0] ma, mb;
  logic signed [tun_pkg::ProdW-1:0] mprod;
  // product order: e0y*e1z, e0z*e1y, e0z*e1x, e0x*e1z, e0x*e1y, e0y*e1x
  always_comb begin
    case ({cmd_i.sub, cmd_i.comp[0]})
      3'b000:  begin ma = e0_q[1]; mb = e1_q[2]; end
      3'b001:  begin ma = e0_q[2]; mb = e1_q[1]; end
      3'b010:  begin ma = e0_q[2]; mb = e1_q[0]; end
      3'b011:  begin ma = e0_q[0]; mb = e1_q[2]; end
      3'b100:  begin ma = e0_q[0]; mb = e1_q[1]; end
      default: begin ma = e0_q[1]; mb = e1_q[0]; end
    endcase
    mprod = ma * mb;
  end

  logic [2:0] fit;
  logic [tun_pkg::MagW-1:0] msel;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fit[j] = (mag_q[j][tun_pkg::CrossW-1:tun_pkg::MagW] == '0);
      cross_val[j] = tun_pkg::CrossW'(prod_q[2*j]) - tun_pkg::CrossW'(prod_q[2*j+1]);
    end
    msel = mag_q[cmd_i.comp][tun_pkg::MagW-1:0];
    mid_c = ({1'b0, lo_q} + {1'b0, hi_q} + 17'd1) >> 1;
    t_c = {mid_c[tun_pkg::KW-1:0], 1'b0} - 17'd1;
    // (2k-1)^2 * l2 from two 64-bit partial products over the 32-bit halves of l2
    lhs_sum = {phi_q, 32'd0} + {32'd0, plo_q};
  end

  assign status_o.zero = (mag_q[0] == '0) && (mag_q[1] == '0) && (mag_q[2] == '0);
  assign status_o.fits = &fit;
  assign status_o.search_done = (lo_q == hi_q);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cb_q <= item_i.corner_b;
      cc_q <= item_i.corner_c;
    end
    case (cmd_i.op)
      tun_pkg::OpReadB: begin
        va_q[0] <= rdata_q[3*tun_pkg::CoordW-1:2*tun_pkg::CoordW];
        va_q[1] <= rdata_q[2*tun_pkg::CoordW-1:tun_pkg::CoordW];
        va_q[2] <= rdata_q[tun_pkg::CoordW-1:0];
      end
      tun_pkg::OpReadC: begin
        vb_q[0] <= rdata_q[3*tun_pkg::CoordW-1:2*tun_pkg::CoordW];
        vb_q[1] <= rdata_q[2*tun_pkg::CoordW-1:tun_pkg::CoordW];
        vb_q[2] <= rdata_q[tun_pkg::CoordW-1:0];
      end
      tun_pkg::OpEdges: begin
        for (int j = 0; j < 3; j++) begin
          e0_q[j] <= tun_pkg::EdgeW'(vb_q[j]) - tun_pkg::EdgeW'(va_q[j]);
          e1_q[j] <= tun_pkg::EdgeW'($signed(
                       rdata_q[(3-j)*tun_pkg::CoordW-1 -: tun_pkg::CoordW]))
                     - tun_pkg::EdgeW'(va_q[j]);
        end
      end
      tun_pkg::OpProd: prod_q[{cmd_i.sub, 1'b0} + {2'b00, cmd_i.comp[0]}] <= mprod;
      tun_pkg::OpCross: begin
        for (int j = 0; j < 3; j++) begin
          neg_q[j] <= cross_val[j][tun_pkg::CrossW-1];
          mag_q[j] <= cross_val[j][tun_pkg::CrossW-1] ? -cross_val[j] : cross_val[j];
        end
      end
      // one bit of common shift a cycle until all fit below 2^31
      tun_pkg::OpShift: begin
        degen_q <= status_o.zero;
        if (!status_o.fits)
          for (int j = 0; j < 3; j++) mag_q[j] <= mag_q[j] >> 1;
      end
      tun_pkg::OpSquare: sq_q[cmd_i.comp] <= tun_pkg::L2W'(msel) * tun_pkg::L2W'(msel);
      tun_pkg::OpSum: l2_q <= sq_q[0] + sq_q[1] + sq_q[2];
      tun_pkg::OpSearchInit: begin
        lo_q  <= '0;
        hi_q  <= tun_pkg::KW'(32768);
        rhs_q <= sq_q[cmd_i.comp];
      end
      tun_pkg::OpSearchMul: begin
        mid_q <= mid_c[tun_pkg::KW-1:0];
        t2_q  <= 32'(t_c) * 32'(t_c);
      end
      tun_pkg::OpSearchPart: begin
        plo_q <= 64'(t2_q) * 64'(l2_q[31:0]);
        phi_q <= 64'(t2_q) * 64'(l2_q[63:32]);
      end
      tun_pkg::OpSearchCmp: begin
        if (!status_o.search_done) begin
          if (lhs_sum <= {rhs_q, 32'd0}) lo_q <= mid_q;
          else hi_q <= mid_q - tun_pkg::KW'(1);
        end else begin
          if (neg_q[cmd_i.comp]) res_q[cmd_i.comp] <= tun_pkg::NormW'(-lo_q);
          else if (lo_q > tun_pkg::KW'(32767)) res_q[cmd_i.comp] <= tun_pkg::NormW'(32767);
          else res_q[cmd_i.comp] <= lo_q;
        end
      end
      default: ;
    endcase
  end

  assign result_o.normal_x   = degen_q ? '0 : res_q[0];
  assign result_o.normal_y   = degen_q ? '0 : res_q[1];
  assign result_o.normal_z   = degen_q ? '0 : res_q[2];
  assign result_o.degenerate = degen_q;

endmodule

// ===== design/triangle_unit_normal.sv =====
// top level of the triangle unit normal block
// Usage: one valid/ready input channel carries in_item_t beats. mode 0 writes
// a Q16.16 vertex into the slot of a single-port vertex memory and gives no
// result; mode 1 reads corners a, b, c (three memory reads) and returns one
// out_item_t beat with the Q1.15 unit face normal and the degenerate flag.
// A new vertex write can be accepted every cycle while no result is held
// stalled. A triangle takes the three reads, six cross-product multiplies
// on one shared multiplier, a common scaling shift of up to 34 bits done
// one bit per step, three squares, and a rounding search of 15 or 16 steps
// per component, each step passing the multiply, partial-product and
// compare states; a degenerate triangle skips the squares and the search.
// One triangle is in flight at a time; the rounding search sets the rate.
// Reset clears the controller and output valid; the vertex memory holds
// nothing defined until written, so read only written slots.
// When the receiver stalls the result stays on out_item_o and no new item
// is taken until it is accepted.
module triangle_unit_normal (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tun_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tun_pkg::out_item_t out_item_o
);

  tun_pkg::dp_cmd_t    cmd;
  tun_pkg::dp_status_t status;
  logic                load;

  tun_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_mode_i   (in_item_i.mode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .status_i    (status),
    .load_o      (load)
  );

  tun_dp u_dp (
    .clk_i    (clk_i),
    .item_i   (in_item_i),
    .load_i   (load),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (out_item_o)
  );

endmodule
